// ===== src/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, operation codes and the control type of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int CAU_COMP_WIDTH  = 16;
  localparam int CAU_FRAC_BITS   = 8;
  localparam int CAU_QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       zdiv;
  } cau_ctl_t;

endpackage
`default_nettype wire

// ===== src/cau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Accepts operand transactions, flags zero divisors and forms the sums and all products.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int W = cau_pkg::CAU_COMP_WIDTH,
  parameter int PW = 2 * (W + 1) + 12 * W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_kind,
  input  wire logic signed [W-1:0]    in_a_re,
  input  wire logic signed [W-1:0]    in_a_im,
  input  wire logic signed [W-1:0]    in_b_re,
  input  wire logic signed [W-1:0]    in_b_im,
  input  wire logic                   q_ready,
  output logic                        q_push,
  output cau_pkg::cau_ctl_t           q_ctl,
  output logic [PW-1:0]               q_data
);
  import cau_pkg::*;

  logic              en1, en2, acc;
  logic              f1_v_r, f2_v_r;
  cau_ctl_t          f1_ctl_r, f2_ctl_r;
  logic signed [W-1:0] ar_r, ai_r, br_r, bi_r;
  logic signed [W:0]   sre_r, sim_r;
  logic signed [2*W-1:0] rr_r, ii_r, ri_r, ir_r, b2r_r, b2i_r;
  logic signed [2*W-1:0] rr_nxt, ii_nxt, ri_nxt, ir_nxt, b2r_nxt, b2i_nxt;
  logic signed [W:0]   sre_nxt, sim_nxt;
  logic              zdiv_nxt;

  // advance a stage when the one after it can take its content
  assign en2  = !f2_v_r || q_ready;
  assign en1  = !f1_v_r || en2;
  assign busy = !en1;
  assign acc  = start && en1;

  assign zdiv_nxt = (in_kind == KIND_DIV) && (in_b_re == '0) && (in_b_im == '0);

  always_comb begin
    rr_nxt  = ar_r * br_r;
    ii_nxt  = ai_r * bi_r;
    ri_nxt  = ar_r * bi_r;
    ir_nxt  = ai_r * br_r;
    b2r_nxt = br_r * br_r;
    b2i_nxt = bi_r * bi_r;
    if (f1_ctl_r.kind == KIND_SUB) begin
      sre_nxt = (W+1)'(ar_r) - (W+1)'(br_r);
      sim_nxt = (W+1)'(ai_r) - (W+1)'(bi_r);
    end else begin
      sre_nxt = (W+1)'(ar_r) + (W+1)'(br_r);
      sim_nxt = (W+1)'(ai_r) + (W+1)'(bi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (en1) f1_v_r <= acc;
      if (en2) f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_ctl_r.kind <= in_kind;
      f1_ctl_r.zdiv <= zdiv_nxt;
      ar_r <= in_a_re;
      ai_r <= in_a_im;
      br_r <= in_b_re;
      bi_r <= in_b_im;
    end
    if (en2 && f1_v_r) begin
      f2_ctl_r <= f1_ctl_r;
      sre_r <= sre_nxt;
      sim_r <= sim_nxt;
      rr_r  <= rr_nxt;
      ii_r  <= ii_nxt;
      ri_r  <= ri_nxt;
      ir_r  <= ir_nxt;
      b2r_r <= b2r_nxt;
      b2i_r <= b2i_nxt;
    end
  end

  assign q_push = f2_v_r && q_ready;
  assign q_ctl  = f2_ctl_r;
  assign q_data = {sre_r, sim_r, rr_r, ii_r, ri_r, ir_r, b2r_r, b2i_r};

endmodule
`default_nettype wire

// ===== src/cau_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module cau_queue #(
  parameter int PW    = 8,
  parameter int DEPTH = cau_pkg::CAU_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cau_pkg::cau_ctl_t push_ctl,
  input  wire logic [PW-1:0]     push_data,
  output logic                   ready,
  input  wire logic              pop,
  output logic                   not_empty,
  output cau_pkg::cau_ctl_t      pop_ctl,
  output logic [PW-1:0]          pop_data
);
  import cau_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cau_ctl_t        ctl_mem [0:DEPTH-1];
  logic [PW-1:0]   data_mem [0:DEPTH-1];
  logic [AW-1:0]   wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign ready     = (cnt_r != CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign pop_ctl   = ctl_mem[rd_r];
  assign pop_data  = data_mem[rd_r];

  always_comb begin
    wr_nxt  = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    rd_nxt  = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)   wr_r <= wr_nxt;
      if (do_pop) rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_r]  <= push_ctl;
      data_mem[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/cau_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Forms numerator and divisor, rounds through a pipelined restoring divider,
// then saturates and drives the result strobe.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int W = cau_pkg::CAU_COMP_WIDTH,
  parameter int F = cau_pkg::CAU_FRAC_BITS,
  parameter int PW = 2 * (W + 1) + 12 * W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  output logic                     q_pop,
  input  wire cau_pkg::cau_ctl_t   q_ctl,
  input  wire logic [PW-1:0]       q_data,
  output logic                     out_valid,
  output logic signed [W-1:0]      out_res_re,
  output logic signed [W-1:0]      out_res_im,
  output logic                     out_overflow_flag,
  output logic                     out_zero_divisor_flag
);
  import cau_pkg::*;

  localparam int PRW = 2 * W;          // product width
  localparam int SW  = PRW + 1;        // sum of two products
  localparam int NW  = SW + F;         // numerator width
  localparam int DW  = PRW + 1;        // divisor width
  localparam int RW  = NW + 1;         // dividend / remainder width
  localparam int EW  = DW + W + RW;    // compare width

  logic signed [W:0]     sre, sim;
  logic signed [PRW-1:0] rr, ii, ri, ir, b2r, b2i;
  logic signed [NW-1:0]  num_re, num_im;
  logic [DW-1:0]         den;

  // unpack in the same order the front packs
  assign {sre, sim, rr, ii, ri, ir, b2r, b2i} = q_data;
  assign q_pop = q_not_empty;

  always_comb begin
    num_re = '0;
    num_im = '0;
    den    = DW'(1);
    case (q_ctl.kind)
      KIND_ADD, KIND_SUB: begin
        num_re = NW'(sre);
        num_im = NW'(sim);
      end
      KIND_MUL: begin
        num_re = NW'(SW'(rr) - SW'(ii));
        num_im = NW'(SW'(ri) + SW'(ir));
        den    = DW'(1) << F;
      end
      KIND_DIV: begin
        if (!q_ctl.zdiv) begin
          num_re = NW'(SW'(rr) + SW'(ii)) <<< F;
          num_im = NW'(SW'(ir) - SW'(ri)) <<< F;
          den    = DW'($unsigned(b2r)) + DW'($unsigned(b2i));
        end
      end
      default: begin
        den = DW'(1);
      end
    endcase
  end

  // stage b1: sign and magnitude
  logic            b1_v_r;
  cau_ctl_t        b1_ctl_r;
  logic            b1_sre_r, b1_sim_r;
  logic [NW-1:0]   b1_mre_r, b1_mim_r;
  logic [DW-1:0]   b1_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else        b1_v_r <= q_pop;
  end

  always_ff @(posedge clk) begin
    b1_ctl_r <= q_ctl;
    b1_sre_r <= num_re[NW-1];
    b1_sim_r <= num_im[NW-1];
    b1_mre_r <= num_re[NW-1] ? NW'(-num_re) : NW'(num_re);
    b1_mim_r <= num_im[NW-1] ? NW'(-num_im) : NW'(num_im);
    b1_den_r <= den;
  end

  // divider stages: index 0 is the rounded dividend, W is the finished quotient
  logic            dv_v_r   [0:W];
  logic            dv_z_r   [0:W];
  logic            dv_sre_r [0:W];
  logic            dv_sim_r [0:W];
  logic            dv_bre_r [0:W];
  logic            dv_bim_r [0:W];
  logic [DW-1:0]   dv_den_r [0:W];
  logic [RW-1:0]   dv_rre_r [0:W];
  logic [RW-1:0]   dv_rim_r [0:W];
  logic [W-1:0]    dv_qre_r [0:W];
  logic [W-1:0]    dv_qim_r [0:W];

  logic [RW-1:0]   dd_re, dd_im;
  logic [EW-1:0]   lim;

  // add half the divisor for round-half-away, flag quotients of 2^W or more
  always_comb begin
    dd_re = RW'(b1_mre_r) + RW'(b1_den_r >> 1);
    dd_im = RW'(b1_mim_r) + RW'(b1_den_r >> 1);
    lim   = EW'(b1_den_r) << W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= b1_v_r;
  end

  always_ff @(posedge clk) begin
    dv_z_r[0]   <= b1_ctl_r.zdiv;
    dv_sre_r[0] <= b1_sre_r;
    dv_sim_r[0] <= b1_sim_r;
    dv_bre_r[0] <= EW'(dd_re) >= lim;
    dv_bim_r[0] <= EW'(dd_im) >= lim;
    dv_den_r[0] <= b1_den_r;
    dv_rre_r[0] <= dd_re;
    dv_rim_r[0] <= dd_im;
    dv_qre_r[0] <= '0;
    dv_qim_r[0] <= '0;
  end

  genvar g;
  generate
    for (g = 0; g < W; g++) begin : g_div
      logic [EW-1:0] dsh;
      logic          ge_re, ge_im;

      always_comb begin
        dsh   = EW'(dv_den_r[g]) << (W - 1 - g);
        ge_re = EW'(dv_rre_r[g]) >= dsh;
        ge_im = EW'(dv_rim_r[g]) >= dsh;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) dv_v_r[g+1] <= 1'b0;
        else        dv_v_r[g+1] <= dv_v_r[g];
      end

      always_ff @(posedge clk) begin
        dv_z_r[g+1]   <= dv_z_r[g];
        dv_sre_r[g+1] <= dv_sre_r[g];
        dv_sim_r[g+1] <= dv_sim_r[g];
        dv_bre_r[g+1] <= dv_bre_r[g];
        dv_bim_r[g+1] <= dv_bim_r[g];
        dv_den_r[g+1] <= dv_den_r[g];
        dv_rre_r[g+1] <= ge_re ? RW'(EW'(dv_rre_r[g]) - dsh) : dv_rre_r[g];
        dv_rim_r[g+1] <= ge_im ? RW'(EW'(dv_rim_r[g]) - dsh) : dv_rim_r[g];
        dv_qre_r[g+1] <= {dv_qre_r[g][W-2:0], ge_re};
        dv_qim_r[g+1] <= {dv_qim_r[g][W-2:0], ge_im};
      end
    end
  endgenerate

  // saturate a signed magnitude to the component range
  function automatic logic [W:0] sat_comp(input logic neg, input logic big,
                                          input logic [W-1:0] q);
    logic [W-1:0] v;
    logic         ovf;
    begin
      if (neg) begin
        ovf = big || (q[W-1] && (q[W-2:0] != '0));
        v   = ovf ? {1'b1, {(W-1){1'b0}}} : W'(~q + 1'b1);
      end else begin
        ovf = big || q[W-1];
        v   = ovf ? {1'b0, {(W-1){1'b1}}} : q;
      end
      sat_comp = {ovf, v};
    end
  endfunction

  logic [W:0] s_re, s_im;

  assign s_re = sat_comp(dv_sre_r[W], dv_bre_r[W], dv_qre_r[W]);
  assign s_im = sat_comp(dv_sim_r[W], dv_bim_r[W], dv_qim_r[W]);

  logic            o_v_r, o_ovf_r, o_z_r;
  logic [W-1:0]    o_re_r, o_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else        o_v_r <= dv_v_r[W];
  end

  always_ff @(posedge clk) begin
    o_re_r  <= s_re[W-1:0];
    o_im_r  <= s_im[W-1:0];
    o_ovf_r <= s_re[W] || s_im[W];
    o_z_r   <= dv_z_r[W];
  end

  assign out_valid             = o_v_r;
  assign out_res_re            = o_re_r;
  assign out_res_im            = o_im_r;
  assign out_overflow_flag     = o_ovf_r;
  assign out_zero_divisor_flag = o_z_r;

endmodule
`default_nettype wire

// ===== src/complex_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex ALU: add, subtract, multiply and divide on signed
// fixed-point components, with rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_kind and the four operand components, raise start. A
//   transaction is taken at a rising edge with start high and busy low.
//   Kinds: add, subtract, multiply, divide (a times conj(b) over |b|^2).
//   Output: each result shows for one cycle with out_valid high; the receiver
//   cannot stall, so take it in that cycle.
//   Path: the operand registers, the product and sum registers, the queue,
//   the sign/magnitude stage, the rounded dividend, the divider stages and
//   the output register. All kinds take the same path, so results keep order.
//   Throughput: one transaction per cycle while busy is low. The front
//   registers operands and runs six multipliers; the back runs a restoring
//   divider with one quotient bit per stage, COMPONENT_WIDTH stages deep.
//   A two-entry queue parts front and back; the back drains it every cycle.
//   Overflow: a saturated component raises out_overflow_flag. A divide by a
//   zero b gives zero and raises out_zero_divisor_flag.
//   Reset: a synchronous rst_n low empties every stage; no result is lost
//   across it only if none is in flight.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
  parameter int COMPONENT_WIDTH = cau_pkg::CAU_COMP_WIDTH,
  parameter int FRACTION_BITS   = cau_pkg::CAU_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_kind,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_a_re,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_a_im,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_b_re,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_b_im,
  output logic                                  out_valid,
  output logic signed [COMPONENT_WIDTH-1:0]     out_res_re,
  output logic signed [COMPONENT_WIDTH-1:0]     out_res_im,
  output logic                                  out_overflow_flag,
  output logic                                  out_zero_divisor_flag
);
  import cau_pkg::*;

  // packed payload: two (W+1)-bit sums and six 2W-bit products
  localparam int PW = 2 * (COMPONENT_WIDTH + 1) + 12 * COMPONENT_WIDTH;

  logic            q_ready, q_push, q_pop, q_not_empty;
  cau_ctl_t        push_ctl, pop_ctl;
  logic [PW-1:0]   push_data, pop_data;

  // front: accept, classify, multiply
  cau_front #(
    .W  (COMPONENT_WIDTH),
    .PW (PW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_kind (in_kind),
    .in_a_re (in_a_re),
    .in_a_im (in_a_im),
    .in_b_re (in_b_re),
    .in_b_im (in_b_im),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_ctl   (push_ctl),
    .q_data  (push_data)
  );

  // queue: decouple front stalls from the back
  cau_queue #(
    .PW    (PW),
    .DEPTH (CAU_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ctl  (push_ctl),
    .push_data (push_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_ctl   (pop_ctl),
    .pop_data  (pop_data)
  );

  // back: round, divide, saturate, strobe out
  cau_back #(
    .W  (COMPONENT_WIDTH),
    .F  (FRACTION_BITS),
    .PW (PW)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_not_empty           (q_not_empty),
    .q_pop                 (q_pop),
    .q_ctl                 (pop_ctl),
    .q_data                (pop_data),
    .out_valid             (out_valid),
    .out_res_re            (out_res_re),
    .out_res_im            (out_res_im),
    .out_overflow_flag     (out_overflow_flag),
    .out_zero_divisor_flag (out_zero_divisor_flag)
  );

endmodule
`default_nettype wire

// ===== src/cau_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int COMPONENT_WIDTH = cau_pkg::CAU_COMP_WIDTH
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 in_kind,
  input wire logic [COMPONENT_WIDTH-1:0] in_b_re,
  input wire logic [COMPONENT_WIDTH-1:0] in_b_im,
  input wire logic                       out_valid,
  input wire logic [COMPONENT_WIDTH-1:0] out_res_re,
  input wire logic [COMPONENT_WIDTH-1:0] out_res_im,
  input wire logic                       out_overflow_flag,
  input wire logic                       out_zero_divisor_flag
);
  import cau_pkg::*;

  // edges from the accepting edge to the edge that takes the result
  localparam int LAT = COMPONENT_WIDTH + 6;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  a_zero_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_DIV && in_b_re == '0 && in_b_im == '0)
      |-> ##LAT (out_valid && out_zero_divisor_flag))
    else $error("zero divisor not flagged");

  a_zero_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_divisor_flag)
      |-> (out_res_re == '0 && out_res_im == '0 && !out_overflow_flag))
    else $error("zero divisor result not cleared");

endmodule

bind complex_arithmetic_unit_top cau_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_cau_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .in_kind               (in_kind),
  .in_b_re               (in_b_re),
  .in_b_im               (in_b_im),
  .out_valid             (out_valid),
  .out_res_re            (out_res_re),
  .out_res_im            (out_res_im),
  .out_overflow_flag     (out_overflow_flag),
  .out_zero_divisor_flag (out_zero_divisor_flag)
);
`default_nettype wire
